[src/omt_pkg.sv]
package omt_pkg;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_LOOKUP = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_REMOVE,
        ST_LOOKUP,
        ST_BAD,
        ST_EMIT_OK
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    ld_in;
        logic    idx_inc;
        logic    wr_add;
        logic    rm_shift;
        logic    pend_ld;
        logic    emit;
        logic    emit_pend;
        logic    emit_last;
        t_status emit_status;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic idx_end;
        logic key_hit;
        logic pair_hit;
        logic full;
        logic out_free;
        logic pend_valid;
    } t_dp_stat;

endpackage

[src/omt_ctrl.sv]
module omt_ctrl
    import omt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic [1:0] i_func,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_func)
                        FUNC_ADD:    n_state = ST_ADD;
                        FUNC_REMOVE: n_state = ST_REMOVE;
                        FUNC_LOOKUP: n_state = ST_LOOKUP;
                        default:     n_state = ST_BAD;
                    endcase
                end
            end
            ST_ADD: begin
                if (!i_stat.full) begin
                    n_state = ST_EMIT_OK;
                end else if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_REMOVE: begin
                if (i_stat.idx_end) begin
                    if (i_stat.out_free) begin
                        n_state = ST_IDLE;
                    end
                end else if (i_stat.pair_hit) begin
                    n_state = ST_EMIT_OK;
                end
            end
            ST_LOOKUP: begin
                if (i_stat.idx_end && i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_BAD, ST_EMIT_OK: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.emit_status = STAT_OK;
        o_cmd.emit_last   = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.ld_in = i_valid;
            end
            ST_ADD: begin
                if (i_stat.full) begin
                    o_cmd.emit        = i_stat.out_free;
                    o_cmd.emit_status = STAT_FULL;
                end else begin
                    o_cmd.wr_add = 1'b1;
                end
            end
            ST_REMOVE: begin
                if (i_stat.idx_end) begin
                    o_cmd.emit        = i_stat.out_free;
                    o_cmd.emit_status = STAT_NOT_FOUND;
                end else if (i_stat.pair_hit) begin
                    o_cmd.rm_shift = 1'b1;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_LOOKUP: begin
                if (i_stat.idx_end) begin
                    o_cmd.emit = i_stat.out_free;
                    if (i_stat.pend_valid) begin
                        o_cmd.emit_pend = 1'b1;
                    end else begin
                        o_cmd.emit_status = STAT_NOT_FOUND;
                    end
                end else if (i_stat.key_hit) begin
                    // a held match goes out only once a later one proves it is not the last
                    if (!i_stat.pend_valid) begin
                        o_cmd.pend_ld = 1'b1;
                        o_cmd.idx_inc = 1'b1;
                    end else if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_pend = 1'b1;
                        o_cmd.emit_last = 1'b0;
                        o_cmd.pend_ld   = 1'b1;
                        o_cmd.idx_inc   = 1'b1;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_BAD: begin
                o_cmd.emit        = i_stat.out_free;
                o_cmd.emit_status = STAT_NOT_FOUND;
            end
            ST_EMIT_OK: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[src/omt_dp.sv]
module omt_dp
    import omt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_value,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_found_value,
    output logic               o_last,
    output logic [4:0]         o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [31:0]   r_keys [CAPACITY];
    logic [31:0]   r_vals [CAPACITY];
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [31:0]   r_key;
    logic [31:0]   r_value;
    logic [31:0]   r_pend;
    logic          r_pend_valid;

    logic [IW-1:0] w_rd;
    logic [IW-1:0] w_wr;
    logic          w_key_eq;

    assign w_rd     = r_idx[IW-1:0];
    assign w_wr     = r_count[IW-1:0];
    assign w_key_eq = (r_keys[w_rd] == r_key);

    assign o_stat.idx_end    = (r_idx == r_count);
    assign o_stat.key_hit    = w_key_eq;
    assign o_stat.pair_hit   = w_key_eq && (r_vals[w_rd] == r_value);
    assign o_stat.full       = (r_count >= CW'(CAPACITY));
    assign o_stat.out_free   = !o_valid || i_ready;
    assign o_stat.pend_valid = r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.pend_ld) begin
            r_pend <= r_vals[w_rd];
        end
        if (i_cmd.wr_add) begin
            r_keys[w_wr] <= r_key;
            r_vals[w_wr] <= r_value;
        end
        // each cell at or above the match takes its upper neighbor
        if (i_cmd.rm_shift) begin
            for (int j = 0; j < CAPACITY - 1; j++) begin
                if (CW'(j) >= r_idx) begin
                    r_keys[j] <= r_keys[j+1];
                    r_vals[j] <= r_vals[j+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cmd.ld_in) begin
                r_idx        <= '0;
                r_pend_valid <= 1'b0;
            end else begin
                if (i_cmd.idx_inc) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (i_cmd.pend_ld) begin
                    r_pend_valid <= 1'b1;
                end
            end
            if (i_cmd.wr_add) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.rm_shift) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status      <= i_cmd.emit_status;
            o_found_value <= i_cmd.emit_pend ? r_pend : 32'd0;
            o_last        <= i_cmd.emit_last;
            o_entry_count <= 5'(r_count);
        end
    end

endmodule

[src/ordered_multimap_table.sv]
// Ordered multimap: up to CAPACITY (key, value) pairs kept in insertion order,
// duplicates allowed. func 0 appends a pair (status full when at capacity), func 1
// deletes the oldest pair matching key and value and closes the gap (status not
// found when none), func 2 returns every value stored under the key, oldest first,
// with last set on the final one, or a single not-found result. Every result
// carries the entry count after the operation. Items are handled one at a time.
// An add loads its operands in the accepting cycle, writes the pair in ST_ADD
// and registers its result from ST_EMIT_OK (a full status from ST_ADD). Remove
// and lookup walk the table through a single compare port, one entry per cycle
// while no held lookup match waits on the output, and lookup results leave at
// most one per cycle as the scan finds them. A result that must go out while the
// output register still holds an untaken one stalls until it is taken. A result
// waits in an output register, so the next item can be accepted while the last
// result is still held.
module ordered_multimap_table
    import omt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_found_value,
    output logic               o_last,
    output logic [4:0]         o_entry_count
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    omt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    omt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_last        (o_last),
        .o_entry_count (o_entry_count)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted again in the cycle after a transaction");

    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != STAT_OK) |-> (o_found_value == 32'sd0))
        else $error("found value not zero on a failed result");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_FULL) |-> (o_entry_count == 5'(CAPACITY)))
        else $error("table full reported below capacity");

    a_not_found_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != STAT_OK) |-> o_last)
        else $error("failed result not marked last");
`endif

endmodule
